// ===== rtl/rom_header_parser_defines.svh =====
// Assertion macros for the cartridge header parser.
`ifndef ROM_HEADER_PARSER_DEFINES_SVH
`define ROM_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("header parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("header parser check failed");

`endif

// ===== rtl/rhp_pkg.sv =====
// Types and constants shared by the header parser modules.
`default_nettype none
package rhp_pkg;

    localparam int unsigned HEADER_BYTES   = 16;
    localparam int unsigned POS_W          = 4;
    localparam int unsigned KEPT_BYTES     = 6;
    localparam int unsigned KIDX_W         = 3;

    localparam logic [POS_W-1:0] SIG_LAST_POS = 4'd3;
    localparam logic [POS_W-1:0] KEPT_FIRST   = 4'd4;
    localparam logic [POS_W-1:0] KEPT_LAST    = 4'd9;
    localparam logic [POS_W-1:0] TAIL_FIRST   = 4'd12;
    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(HEADER_BYTES - 1);

    localparam logic [31:0] HDR_BLOCK_LEN = 32'(HEADER_BYTES);
    localparam logic [31:0] TRAINER_LEN   = 32'd512;

    localparam logic [7:0] SIG_BYTES [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

    localparam logic [1:0] NES2_MARK      = 2'b10;
    localparam logic [1:0] CON_HOME       = 2'd0;
    localparam logic [1:0] CON_PLAYCHOICE = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_NES2      = 3'd2,
        ST_TRAINER   = 3'd3,
        ST_CONSOLE   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FMT_ARCHAIC = 2'd0,
        FMT_INES    = 2'd1,
        FMT_NES2    = 2'd2
    } t_format;

    // Snapshot of one complete header, handed from collector to decoder.
    typedef struct packed {
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
        logic [7:0] b8;
        logic [7:0] b9;
        logic       sig_ok;
        logic       tail_nz;
    } t_hdr;

    typedef struct packed {
        t_status    status;
        t_format    file_format;
        logic [7:0] mapper_id;
        logic [7:0] prg_rom_banks;
        logic [7:0] chr_rom_banks;
        logic [7:0] prg_ram_units;
        logic       vertical_mirroring;
        logic       battery_ram;
        logic       four_screen;
        logic [1:0] console_type;
        logic       pal_tv;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/rhp_ifs.sv =====
// Stream interfaces for header bytes in and decoded results out.
`default_nettype none
interface rhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;

    modport source (output valid, output header_byte, input ready);
    modport sink   (input valid, input header_byte, output ready);
endinterface

interface rhp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] file_format;
    logic [7:0] mapper_id;
    logic [7:0] prg_rom_banks;
    logic [7:0] chr_rom_banks;
    logic [7:0] prg_ram_units;
    logic       vertical_mirroring;
    logic       battery_ram;
    logic       four_screen;
    logic [1:0] console_type;
    logic       pal_tv;

    modport source (
        output valid, output status, output file_format, output mapper_id,
        output prg_rom_banks, output chr_rom_banks, output prg_ram_units,
        output vertical_mirroring, output battery_ram, output four_screen,
        output console_type, output pal_tv, input ready
    );
    modport sink (
        input valid, input status, input file_format, input mapper_id,
        input prg_rom_banks, input chr_rom_banks, input prg_ram_units,
        input vertical_mirroring, input battery_ram, input four_screen,
        input console_type, input pal_tv, output ready
    );
endinterface
`default_nettype wire

// ===== rtl/rhp_collect.sv =====
// Byte collector: position count, signature and tail flags, kept bytes 4 to 9.
`default_nettype none
module rhp_collect (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rhp_in_if.sink      i_hdr,
    input  wire logic   i_take,
    output logic        o_pend,
    output rhp_pkg::t_hdr o_hdr
);
    import rhp_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_sig_ok, n_sig_ok;
    logic              r_tail_nz, n_tail_nz;
    logic              r_pend, n_pend;
    logic [7:0]        r_kept [KEPT_BYTES];
    t_hdr              r_hdr;

    logic              w_xfer;
    logic              w_last;
    logic              w_tail_hit;
    logic [KIDX_W-1:0] w_kidx;

    // a finished header waits in r_hdr; the next byte enters once it leaves
    assign i_hdr.ready = !r_pend || i_take;
    assign w_xfer      = i_hdr.valid && i_hdr.ready;
    assign w_last      = (r_pos == LAST_POS);
    assign w_kidx      = KIDX_W'(r_pos - KEPT_FIRST);
    assign w_tail_hit  = (r_pos >= TAIL_FIRST) && (i_hdr.header_byte != 8'd0);

    always_comb begin
        n_pos     = r_pos;
        n_sig_ok  = r_sig_ok;
        n_tail_nz = r_tail_nz;
        n_pend    = r_pend && !i_take;
        if (w_xfer) begin
            if (w_last) begin
                n_pos     = '0;
                n_sig_ok  = 1'b1;
                n_tail_nz = 1'b0;
                n_pend    = 1'b1;
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (r_pos <= SIG_LAST_POS &&
                    i_hdr.header_byte != SIG_BYTES[r_pos[1:0]]) begin
                    n_sig_ok = 1'b0;
                end
                if (w_tail_hit) begin
                    n_tail_nz = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_sig_ok  <= 1'b1;
            r_tail_nz <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_sig_ok  <= n_sig_ok;
            r_tail_nz <= n_tail_nz;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer && r_pos >= KEPT_FIRST && r_pos <= KEPT_LAST) begin
            r_kept[w_kidx] <= i_hdr.header_byte;
        end
        if (w_xfer && w_last) begin
            r_hdr.b4      <= r_kept[0];
            r_hdr.b5      <= r_kept[1];
            r_hdr.b6      <= r_kept[2];
            r_hdr.b7      <= r_kept[3];
            r_hdr.b8      <= r_kept[4];
            r_hdr.b9      <= r_kept[5];
            r_hdr.sig_ok  <= r_sig_ok;
            r_hdr.tail_nz <= r_tail_nz || w_tail_hit;
        end
    end

    assign o_pend = r_pend;
    assign o_hdr  = r_hdr;

endmodule
`default_nettype wire

// ===== rtl/rhp_decode.sv =====
// Header decoder: format choice, NES 2.0 size check, field extraction, status.
`default_nettype none
module rhp_decode #(
    parameter int unsigned PLAYCHOICE_EXTRA_BYTES = 8224
) (
    input  rhp_pkg::t_hdr    i_hdr,
    input  wire logic [31:0] i_file_size,
    output rhp_pkg::t_result o_res
);
    import rhp_pkg::*;

    logic        w_trainer;
    logic [1:0]  w_console;
    logic [31:0] w_prg_size;
    logic [31:0] w_chr_size;
    logic [31:0] w_need;
    t_format     w_fmt;

    assign w_trainer  = i_hdr.b6[2];
    assign w_console  = i_hdr.b7[1:0];
    // 12-bit bank counts, high nibbles from byte 9
    assign w_prg_size = {6'd0, i_hdr.b9[3:0], i_hdr.b4, 14'd0};
    assign w_chr_size = {7'd0, i_hdr.b9[7:4], i_hdr.b5, 13'd0};
    assign w_need     = HDR_BLOCK_LEN + (w_trainer ? TRAINER_LEN : 32'd0)
                      + w_prg_size + w_chr_size
                      + ((w_console == CON_PLAYCHOICE) ?
                         32'(PLAYCHOICE_EXTRA_BYTES) : 32'd0);

    always_comb begin
        if (i_hdr.b7[3:2] == NES2_MARK && w_need <= i_file_size) begin
            w_fmt = FMT_NES2;
        end else if (i_hdr.tail_nz) begin
            w_fmt = FMT_ARCHAIC;
        end else begin
            w_fmt = FMT_INES;
        end
    end

    always_comb begin
        o_res.file_format        = w_fmt;
        o_res.prg_rom_banks      = i_hdr.b4;
        o_res.chr_rom_banks      = i_hdr.b5;
        o_res.vertical_mirroring = i_hdr.b6[0];
        o_res.battery_ram        = i_hdr.b6[1];
        o_res.four_screen        = i_hdr.b6[3];
        if (w_fmt == FMT_ARCHAIC) begin
            o_res.mapper_id     = {4'd0, i_hdr.b6[7:4]};
            o_res.console_type  = CON_HOME;
            o_res.prg_ram_units = 8'd1;
            o_res.pal_tv        = 1'b0;
        end else begin
            o_res.mapper_id     = {i_hdr.b7[7:4], i_hdr.b6[7:4]};
            o_res.console_type  = w_console;
            o_res.prg_ram_units = (i_hdr.b8 == 8'd0) ? 8'd1 : i_hdr.b8;
            o_res.pal_tv        = i_hdr.b9[0];
        end

        priority if (!i_hdr.sig_ok) begin
            o_res.status = ST_BAD_SIG;
        end else if (w_fmt == FMT_NES2) begin
            o_res.status = ST_NES2;
        end else if (w_trainer) begin
            o_res.status = ST_TRAINER;
        end else if (w_fmt == FMT_INES && w_console != CON_HOME) begin
            o_res.status = ST_CONSOLE;
        end else begin
            o_res.status = ST_OK;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rom_header_parser.sv =====
// Top level of the cartridge header parser.
`default_nettype none
`include "rom_header_parser_defines.svh"
// Takes the 16 header bytes of a cartridge image, one byte per transfer on
// i_hdr, at up to one byte per cycle, and gives one decoded result on o_res
// per 16 bytes. The header is snapshotted at the transfer of the sixteenth
// byte, and moves through the decoder into the output register, which holds
// the result, once that register is empty or being read. A finished
// header waits in the snapshot register while the output register is held;
// input stalls only when both are full.
// i_cfg_wr_data is the image file size for the NES 2.0 size check; it must be
// written while no header is in flight, which the block does not enforce.
module rom_header_parser #(
    parameter int unsigned PLAYCHOICE_EXTRA_BYTES = 8224
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rhp_in_if.sink           i_hdr,
    rhp_out_if.source        o_res,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);
    import rhp_pkg::*;

    logic [31:0] r_file_size;
    logic        r_out_valid, n_out_valid;
    t_result     r_res;

    logic        w_pend;
    logic        w_take;
    t_hdr        w_hdr;
    t_result     w_dec;

    assign w_take = w_pend && (!r_out_valid || o_res.ready);

    rhp_collect u_collect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (i_hdr),
        .i_take  (w_take),
        .o_pend  (w_pend),
        .o_hdr   (w_hdr)
    );

    rhp_decode #(
        .PLAYCHOICE_EXTRA_BYTES (PLAYCHOICE_EXTRA_BYTES)
    ) u_decode (
        .i_hdr       (w_hdr),
        .i_file_size (r_file_size),
        .o_res       (w_dec)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_file_size <= i_cfg_wr_data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= w_dec;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.status             = r_res.status;
    assign o_res.file_format        = r_res.file_format;
    assign o_res.mapper_id          = r_res.mapper_id;
    assign o_res.prg_rom_banks      = r_res.prg_rom_banks;
    assign o_res.chr_rom_banks      = r_res.chr_rom_banks;
    assign o_res.prg_ram_units      = r_res.prg_ram_units;
    assign o_res.vertical_mirroring = r_res.vertical_mirroring;
    assign o_res.battery_ram        = r_res.battery_ram;
    assign o_res.four_screen        = r_res.four_screen;
    assign o_res.console_type       = r_res.console_type;
    assign o_res.pal_tv             = r_res.pal_tv;

    // a held header is never dropped
    `RHP_ASSERT_NXT(a_pend_held, i_clk, i_rst_n, w_pend && !w_take, w_pend)
    // a header leaving the snapshot always lands in the output register
    `RHP_ASSERT_NXT(a_take_lands, i_clk, i_rst_n, w_take, o_res.valid)
    // no byte may enter while a finished header cannot move on
    `RHP_ASSERT_IMP(a_stall_in, i_clk, i_rst_n, w_pend && !w_take, !i_hdr.ready)
    // archaic images report home console, one RAM unit and no PAL flag
    `RHP_ASSERT_IMP(a_archaic, i_clk, i_rst_n,
        o_res.valid && o_res.file_format == FMT_ARCHAIC,
        o_res.console_type == CON_HOME && o_res.prg_ram_units == 8'd1 && !o_res.pal_tv)

endmodule
`default_nettype wire
